[rtl/assert_macros.svh]
// Assertion helpers shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked at every rising edge outside reset.
`define CHECK_ALWAYS(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("%m: check failed");

// Antecedent in one cycle implies consequent in the next.
`define CHECK_NEXT(label, clk, rst_n, pre, post) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error("%m: check failed");

`endif

[rtl/bffp_pkg.sv]
package bffp_pkg;

    // Default geometry of the bit store
    localparam int WORD_BITS_DEF = 64;
    localparam int WORDS_DEF     = 4;

    // Field widths
    localparam int CMD_W      = 3;
    localparam int START_W    = 8;
    localparam int IDX_W      = 9;
    localparam int CNT_W      = 9;
    localparam int CFG_DATA_W = 32;
    localparam int CFG_ADDR_W = 3;

    localparam logic [CNT_W-1:0] BIT_COUNT_RST = 9'd256;

    // Register index, taken from the word address bit of paddr
    localparam logic REG_BIT_COUNT = 1'b0;

    // Command codes; unlisted codes behave as a query
    localparam logic [CMD_W-1:0] CMD_CLEAR     = 3'd0;
    localparam logic [CMD_W-1:0] CMD_SET       = 3'd1;
    localparam logic [CMD_W-1:0] CMD_POP_FIRST = 3'd2;
    localparam logic [CMD_W-1:0] CMD_POP_FROM  = 3'd3;
    localparam logic [CMD_W-1:0] CMD_QUERY     = 3'd4;

endpackage

[rtl/bffp_item_if.sv]
interface bffp_item_if;
    logic                          valid;
    logic                          ready;
    logic [bffp_pkg::CMD_W-1:0]    cmd;
    logic [bffp_pkg::START_W-1:0]  start_index;

    modport source (output valid, cmd, start_index, input ready);
    modport sink   (input valid, cmd, start_index, output ready);
endinterface

[rtl/bffp_result_if.sv]
interface bffp_result_if;
    logic                        valid;
    logic                        ready;
    logic [bffp_pkg::IDX_W-1:0]  popped;
    logic [bffp_pkg::IDX_W-1:0]  first_set;
    logic [bffp_pkg::IDX_W-1:0]  last_set;
    logic                        all_true;
    logic                        all_false;
    logic                        any_true;
    logic                        any_false;

    modport source (output valid, popped, first_set, last_set, all_true, all_false,
                    any_true, any_false, input ready);
    modport sink   (input valid, popped, first_set, last_set, all_true, all_false,
                    any_true, any_false, output ready);
endinterface

[rtl/bffp_ram.sv]
module bffp_ram #(
    parameter int WIDTH = bffp_pkg::WORD_BITS_DEF,
    parameter int DEPTH = bffp_pkg::WORDS_DEF
) (
    input  logic                                 clk,
    input  logic                                 wr_en,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
    input  logic [WIDTH-1:0]                     wr_data,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
    output logic [WIDTH-1:0]                     rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    // One write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule

[rtl/bitmap_find_first_pop.sv]
// Bit store with find-first-set and pop.
// item channel: cmd (clear all, set all, pop first, pop from start_index,
//   query) and start_index. result channel: popped index plus one (zero when
//   nothing popped), first/last set live index (live size when empty) and the
//   all/any flags over the live bits, all taken after the command.
// APB register 0 (bit_count) sets the number of live bits; write it only
//   while no transaction is in flight. pready is tied high.
// Operation: a transaction scans the words in order. One stored word is read,
//   updated and written back per cycle through a single RAM read port. The
//   result is loaded into the output register with the last word, or from a
//   hold state once that register frees up; a new item waits until then.
// The result sits in an output register: the next item is accepted while it
//   waits. If the receiver still stalls when the following result is done,
//   the block holds it and stays not ready until the register frees up.
// Reset: store reads as all zeros (per-word valid bits), bit_count = 256,
//   no result pending. No clearing pass is needed.
`include "assert_macros.svh"

module bitmap_find_first_pop #(
    parameter int WORD_BITS = bffp_pkg::WORD_BITS_DEF,
    parameter int WORDS     = bffp_pkg::WORDS_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    bffp_item_if.sink                           item,
    bffp_result_if.source                       result,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [bffp_pkg::CFG_ADDR_W-1:0]     paddr,
    input  logic [bffp_pkg::CFG_DATA_W-1:0]     pwdata,
    output logic [bffp_pkg::CFG_DATA_W-1:0]     prdata,
    output logic                                pready
);

    localparam int CAP  = WORD_BITS * WORDS;
    localparam int IW   = $clog2(CAP + 1);
    localparam int SW   = IW > bffp_pkg::IDX_W ? IW : bffp_pkg::IDX_W;
    localparam int AW   = WORDS > 1 ? $clog2(WORDS) : 1;
    localparam int BW   = $clog2(WORD_BITS);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_SCAN = 2'd1;
    localparam logic [1:0] ST_HOLD = 2'd2;

    typedef logic [WORD_BITS-1:0] word_t;
    typedef logic [SW-1:0]        pos_t;

    // Bits j of the word at base with base + j < lim
    function automatic word_t mask_below(input pos_t lim, input pos_t base);
        word_t all_ones;
        pos_t  d;
        all_ones = '1;
        d = lim - base;
        if (lim <= base)
            return '0;
        else if (d >= SW'(WORD_BITS))
            return all_ones;
        else
            return ~(all_ones << d);
    endfunction

    function automatic logic [BW-1:0] low_bit(input word_t v);
        logic [BW-1:0] idx;
        idx = '0;
        for (int i = WORD_BITS - 1; i >= 0; i--)
        begin
            if (v[i])
                idx = BW'(i);
        end
        return idx;
    endfunction

    function automatic logic [BW-1:0] high_bit(input word_t v);
        logic [BW-1:0] idx;
        idx = '0;
        for (int i = 0; i < WORD_BITS; i++)
        begin
            if (v[i])
                idx = BW'(i);
        end
        return idx;
    endfunction

    // Control state
    logic [1:0]                      state_reg, state_next;
    logic [AW-1:0]                   w_reg, w_next;
    logic                            out_valid_reg, out_valid_next;
    logic [WORDS-1:0]                valid_reg, valid_next;
    logic [bffp_pkg::CNT_W-1:0]      bit_count_reg, bit_count_next;

    // Per-transaction working registers
    logic [bffp_pkg::CMD_W-1:0]      cmd_reg, cmd_next;
    pos_t                            lo_reg, lo_next;
    pos_t                            size_reg, size_next;
    pos_t                            base_reg, base_next;
    logic                            found_reg, found_next;
    pos_t                            popped_reg, popped_next;
    pos_t                            first_reg, first_next;
    pos_t                            last_reg, last_next;
    logic                            ffound_reg, ffound_next;
    logic                            any_t_reg, any_t_next;
    logic                            any_f_reg, any_f_next;

    // Output register
    logic [bffp_pkg::IDX_W-1:0]      o_popped_reg, o_popped_next;
    logic [bffp_pkg::IDX_W-1:0]      o_first_reg, o_first_next;
    logic [bffp_pkg::IDX_W-1:0]      o_last_reg, o_last_next;
    logic                            o_any_t_reg, o_any_t_next;
    logic                            o_any_f_reg, o_any_f_next;

    // Datapath
    word_t                           rd_data;
    word_t                           word_cur;
    word_t                           live;
    word_t                           lo_ok;
    word_t                           cand;
    word_t                           new_word;
    word_t                           nv;
    word_t                           zero_live;
    logic [BW-1:0]                   pop_bit;
    logic                            is_pop;
    logic                            is_fill;
    logic                            pop_hit;
    logic                            last_word;
    logic                            out_free;
    logic                            load;
    logic                            cfg_wr;
    logic [AW-1:0]                   rd_addr;
    pos_t                            size_cfg;

    bffp_ram #(
        .WIDTH (WORD_BITS),
        .DEPTH (WORDS)
    ) u_store (
        .clk     (clk),
        .wr_en   (state_reg == ST_SCAN),
        .wr_addr (w_reg),
        .wr_data (new_word),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    // Config port
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;
    assign prdata = (paddr[2] == bffp_pkg::REG_BIT_COUNT)
                    ? bffp_pkg::CFG_DATA_W'(bit_count_reg) : '0;

    // Live size clamped to store capacity
    assign size_cfg = (SW'(bit_count_reg) > SW'(CAP)) ? SW'(CAP) : SW'(bit_count_reg);

    // Handshakes
    assign item.ready = (state_reg == ST_IDLE);
    assign out_free   = !out_valid_reg || result.ready;
    assign last_word  = (w_reg == AW'(WORDS - 1));
    assign rd_addr    = (state_reg == ST_SCAN) ? w_reg + AW'(1) : '0;

    assign is_pop  = (cmd_reg == bffp_pkg::CMD_POP_FIRST) || (cmd_reg == bffp_pkg::CMD_POP_FROM);
    assign is_fill = (cmd_reg == bffp_pkg::CMD_CLEAR) || (cmd_reg == bffp_pkg::CMD_SET);

    // Word update: fill or pop, then masked view for the summary
    always_comb
    begin
        word_cur  = valid_reg[w_reg] ? rd_data : '0;
        live      = mask_below(size_reg, base_reg);
        lo_ok     = ~mask_below(lo_reg, base_reg);
        cand      = word_cur & live & lo_ok;
        pop_bit   = low_bit(cand);
        pop_hit   = is_pop && !found_reg && (cand != '0);
        new_word  = word_cur;
        if (is_fill && (live != '0))
            new_word = (cmd_reg == bffp_pkg::CMD_SET) ? '1 : '0;
        else if (pop_hit)
            new_word = word_cur & ~(word_t'(1) << pop_bit);
        nv        = new_word & live;
        zero_live = ~new_word & live;
    end

    // Sequencer
    always_comb
    begin
        state_next     = state_reg;
        w_next         = w_reg;
        valid_next     = valid_reg;
        bit_count_next = bit_count_reg;
        cmd_next       = cmd_reg;
        lo_next        = lo_reg;
        size_next      = size_reg;
        base_next      = base_reg;
        found_next     = found_reg;
        popped_next    = popped_reg;
        first_next     = first_reg;
        last_next      = last_reg;
        ffound_next    = ffound_reg;
        any_t_next     = any_t_reg;
        any_f_next     = any_f_reg;
        load           = 1'b0;

        if (cfg_wr && (paddr[2] == bffp_pkg::REG_BIT_COUNT))
            bit_count_next = pwdata[bffp_pkg::CNT_W-1:0];

        unique case (state_reg)
            ST_IDLE:
            begin
                if (item.valid)
                begin
                    cmd_next    = item.cmd;
                    lo_next     = (item.cmd == bffp_pkg::CMD_POP_FROM)
                                  ? SW'(item.start_index) : '0;
                    size_next   = size_cfg;
                    base_next   = '0;
                    w_next      = '0;
                    found_next  = 1'b0;
                    popped_next = '0;
                    first_next  = size_cfg;
                    last_next   = size_cfg;
                    ffound_next = 1'b0;
                    any_t_next  = 1'b0;
                    any_f_next  = 1'b0;
                    state_next  = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                valid_next[w_reg] = 1'b1;
                if (pop_hit)
                begin
                    found_next  = 1'b1;
                    popped_next = base_reg + SW'(pop_bit) + SW'(1);
                end
                if (zero_live != '0)
                    any_f_next = 1'b1;
                if (nv != '0)
                begin
                    any_t_next = 1'b1;
                    last_next  = base_reg + SW'(high_bit(nv));
                    if (!ffound_reg)
                    begin
                        first_next  = base_reg + SW'(low_bit(nv));
                        ffound_next = 1'b1;
                    end
                end
                if (last_word)
                begin
                    if (out_free)
                    begin
                        load       = 1'b1;
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        state_next = ST_HOLD;
                    end
                end
                else
                begin
                    w_next    = w_reg + AW'(1);
                    base_next = base_reg + SW'(WORD_BITS);
                end
            end
            ST_HOLD:
            begin
                if (out_free)
                begin
                    load       = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Output register load
    always_comb
    begin
        out_valid_next = out_valid_reg && !result.ready;
        o_popped_next  = o_popped_reg;
        o_first_next   = o_first_reg;
        o_last_next    = o_last_reg;
        o_any_t_next   = o_any_t_reg;
        o_any_f_next   = o_any_f_reg;
        if (load)
        begin
            out_valid_next = 1'b1;
            o_popped_next  = popped_next[bffp_pkg::IDX_W-1:0];
            o_first_next   = first_next[bffp_pkg::IDX_W-1:0];
            o_last_next    = last_next[bffp_pkg::IDX_W-1:0];
            o_any_t_next   = any_t_next;
            o_any_f_next   = any_f_next;
        end
    end

    assign result.valid     = out_valid_reg;
    assign result.popped    = o_popped_reg;
    assign result.first_set = o_first_reg;
    assign result.last_set  = o_last_reg;
    assign result.all_true  = !o_any_f_reg;
    assign result.all_false = !o_any_t_reg;
    assign result.any_true  = o_any_t_reg;
    assign result.any_false = o_any_f_reg;

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            w_reg         <= '0;
            out_valid_reg <= 1'b0;
            valid_reg     <= '0;
            bit_count_reg <= bffp_pkg::BIT_COUNT_RST;
        end
        else
        begin
            state_reg     <= state_next;
            w_reg         <= w_next;
            out_valid_reg <= out_valid_next;
            valid_reg     <= valid_next;
            bit_count_reg <= bit_count_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        cmd_reg      <= cmd_next;
        lo_reg       <= lo_next;
        size_reg     <= size_next;
        base_reg     <= base_next;
        found_reg    <= found_next;
        popped_reg   <= popped_next;
        first_reg    <= first_next;
        last_reg     <= last_next;
        ffound_reg   <= ffound_next;
        any_t_reg    <= any_t_next;
        any_f_reg    <= any_f_next;
        o_popped_reg <= o_popped_next;
        o_first_reg  <= o_first_next;
        o_last_reg   <= o_last_next;
        o_any_t_reg  <= o_any_t_next;
        o_any_f_reg  <= o_any_f_next;
    end

    // Only pop commands report a popped index
    `CHECK_ALWAYS(a_pop_only_on_pop, clk, rst_n, !(load && (popped_next != '0)) || is_pop)
    // A popped index never exceeds the live size
    `CHECK_ALWAYS(a_pop_in_range, clk, rst_n, !load || (popped_next <= size_reg))
    // Empty live set on both counts only happens with a zero size
    `CHECK_ALWAYS(a_empty_live, clk, rst_n, !(load && !any_t_next && !any_f_next) || (size_reg == '0))
    // Accepted item starts its scan at word zero
    `CHECK_NEXT(a_scan_start, clk, rst_n, item.valid && item.ready,
                (state_reg == ST_SCAN) && (w_reg == '0))

endmodule
